### src/integer_line_stepper_macros.svh
// ----------------------------------------------------------------------------
// integer_line_stepper assertion macros
// shared property forms for the line stepper checks, clocked on clk and
// disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef INTEGER_LINE_STEPPER_MACROS_SVH
`define INTEGER_LINE_STEPPER_MACROS_SVH

// same-cycle implication
`define ILS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("line stepper check failed");

// next-cycle implication
`define ILS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("line stepper check failed");

`endif

### src/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// types and constants shared by the integer line stepper modules
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

	localparam int COORD_W       = 6;
	localparam int ERR_W         = 7;
	localparam int GRID_SIZE_DEF = 64;

	// one line request
	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
	} line_req_t;

	// one emitted raster point
	typedef struct packed {
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
		logic               last_point;
	} line_pt_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic left_zero;
		logic left_one;
	} dp_status_t;

endpackage

`default_nettype wire

### src/ils_datapath.sv
// ----------------------------------------------------------------------------
// ils_datapath
// cursor, error accumulator and point counter of the line stepper, plus the
// output point register
// ----------------------------------------------------------------------------
`default_nettype none

module ils_datapath
	import ils_pkg::*;
#(
	parameter int GRID_SIZE = GRID_SIZE_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire line_req_t  line,
	input  wire dp_cmd_t    cmd,
	output dp_status_t      status,
	output line_pt_t        point
);

	localparam logic [COORD_W:0]   GRID_LIM  = (COORD_W+1)'(GRID_SIZE);
	localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIZE - 1);

	function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
		return ({1'b0, v} >= GRID_LIM) ? COORD_MAX : v;
	endfunction

	logic [COORD_W-1:0] cursor_x_q, cursor_y_q;
	logic [ERR_W-1:0]   err_q;
	logic [COORD_W-1:0] left_q;
	logic [COORD_W-1:0] major_q, minor_q;
	logic               y_major_q, major_down_q, minor_down_q;
	line_pt_t           point_q;

	// setup of a new line
	logic [COORD_W-1:0] sx, sy, ex, ey, dx, dy;
	logic               x_down, y_down, y_major;
	logic [COORD_W-1:0] major_d, minor_d;

	always_comb begin
		sx      = clamp(line.start_x);
		sy      = clamp(line.start_y);
		ex      = clamp(line.end_x);
		ey      = clamp(line.end_y);
		x_down  = ex < sx;
		y_down  = ey < sy;
		dx      = x_down ? (sx - ex) : (ex - sx);
		dy      = y_down ? (sy - ey) : (ey - sy);
		y_major = dx < dy;
		major_d = y_major ? dy : dx;
		minor_d = y_major ? dx : dy;
	end

	// one step along the line
	logic [COORD_W-1:0] maj_c, min_c, maj_n, min_n;
	logic [ERR_W-1:0]   err_sum;
	logic               minor_step;

	always_comb begin
		maj_c      = y_major_q ? cursor_y_q : cursor_x_q;
		min_c      = y_major_q ? cursor_x_q : cursor_y_q;
		maj_n      = major_down_q ? (maj_c - 1'b1) : (maj_c + 1'b1);
		err_sum    = err_q + {1'b0, minor_q};
		minor_step = err_sum >= {1'b0, major_q};
		min_n      = min_c;
		if (minor_step) begin
			min_n = minor_down_q ? (min_c - 1'b1) : (min_c + 1'b1);
		end
	end

	// point counter is control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (cmd.load) begin
			left_q <= major_d;
		end else if (cmd.step) begin
			left_q <= left_q - 1'b1;
		end
	end

	// line registers and output point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q   <= '0;
			cursor_y_q   <= '0;
			major_q      <= '0;
			minor_q      <= '0;
			y_major_q    <= 1'b0;
			major_down_q <= 1'b0;
			minor_down_q <= 1'b0;
			err_q        <= '0;
			point_q      <= '0;
		end else if (cmd.load) begin
			cursor_x_q   <= sx;
			cursor_y_q   <= sy;
			major_q      <= major_d;
			minor_q      <= minor_d;
			y_major_q    <= y_major;
			major_down_q <= y_major ? y_down : x_down;
			minor_down_q <= y_major ? x_down : y_down;
			err_q        <= {2'b00, major_d[COORD_W-1:1]};
		end else if (cmd.step) begin
			point_q.point_x    <= cursor_x_q;
			point_q.point_y    <= cursor_y_q;
			point_q.last_point <= (left_q == COORD_W'(1));
			cursor_x_q         <= y_major_q ? min_n : maj_n;
			cursor_y_q         <= y_major_q ? maj_n : min_n;
			err_q              <= minor_step ? (err_sum - {1'b0, major_q}) : err_sum;
		end
	end

	assign status.left_zero = (left_q == '0);
	assign status.left_one  = (left_q == COORD_W'(1));
	assign point            = point_q;

endmodule

`default_nettype wire

### src/ils_ctrl.sv
// ----------------------------------------------------------------------------
// ils_ctrl
// controller of the line stepper: takes a line request when idle, then
// issues one step per point while the output register can take it
// ----------------------------------------------------------------------------
`default_nettype none

module ils_ctrl
	import ils_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       line_valid,
	output logic            line_stall,
	output logic            point_valid,
	input  wire logic       point_stall,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// output register can take a new point this cycle
	assign out_free = !out_valid_q || !point_stall;

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && line_valid;
		cmd.step = (state_q == ST_RUN) && !status.left_zero && out_free;
	end

	assign line_stall  = (state_q != ST_IDLE);
	assign point_valid = out_valid_q;

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (!point_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (line_valid) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (status.left_zero || (cmd.step && status.left_one)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### src/integer_line_stepper.sv
// ----------------------------------------------------------------------------
// integer_line_stepper
// emits the raster points of a grid line from a start to an end coordinate
// ----------------------------------------------------------------------------
// Usage:
//   line channel: a request holds start and end coordinates; it is taken when
//   line_valid is high and line_stall is low. line_stall stays high while a
//   line is being stepped, so one line is in work at a time.
//   point channel: one item per raster point, start point first, end point
//   left out; the final point has last_point set. Equal endpoints give none.
// Sequence and throughput:
//   a taken request is loaded into the line registers; each step then moves the
//   current point into the output point register, one point per cycle while
//   the output register is free, set by the single step of the error accumulator.
// Reset:
//   arst_n clears the controller and the line registers; no point is shown.
// Stall:
//   while point_stall holds a waiting point, that point stays and stepping pauses.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_line_stepper
	import ils_pkg::*;
#(
	parameter int GRID_SIZE = GRID_SIZE_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      line_valid,
	output logic           line_stall,
	input  wire line_req_t line,
	output logic           point_valid,
	input  wire logic      point_stall,
	output line_pt_t       point
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencing
	ils_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.line_valid  (line_valid),
		.line_stall  (line_stall),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.status      (status),
		.cmd         (cmd)
	);

	// line arithmetic and output point
	ils_datapath #(
		.GRID_SIZE (GRID_SIZE)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.line   (line),
		.cmd    (cmd),
		.status (status),
		.point  (point)
	);

endmodule

`default_nettype wire

### src/ils_checker.sv
// ----------------------------------------------------------------------------
// ils_checker
// port-level checks on the line stepper, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_line_stepper_macros.svh"

module ils_checker
	import ils_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      line_valid,
	input wire logic      line_stall,
	input wire line_req_t line,
	input wire logic      point_valid,
	input wire logic      point_stall,
	input wire line_pt_t  point
);

	// a stalled point holds
	`ILS_ASSERT_NEXT(a_point_hold, point_valid && point_stall, point_valid && $stable(point))

	// a taken request makes the block busy
	`ILS_ASSERT_NEXT(a_busy_after_req, line_valid && !line_stall, line_stall)

	// an unfinished line keeps requests out
	`ILS_ASSERT_NOW(a_busy_mid_line, point_valid && !point.last_point, line_stall)

endmodule

bind integer_line_stepper ils_checker u_ils_checker (.*);

`default_nettype wire

### bench/integer_line_stepper_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_line_stepper_tb
// drives line requests into the stepper and checks every raster point against
// a local line tracer: directed corner cases first, then random lines under
// free-running, idle, stalled and held-off traffic
// ----------------------------------------------------------------------------

module integer_line_stepper_tb;
	import ils_pkg::*;

	localparam int GRID_CELLS = GRID_SIZE_DEF;
	localparam int REQ_W      = $bits(line_req_t);
	localparam int LOG_CAP    = 40;

	logic      clk         = 1'b0;
	logic      arst_n;
	logic      line_valid;
	logic      line_stall;
	line_req_t line;
	logic      point_valid;
	logic      point_stall = 1'b0;
	line_pt_t  point;

	line_pt_t expected_points[$];
	int       lines_sent     = 0;
	int       points_seen    = 0;
	int       mismatches     = 0;
	int       src_idle_pct   = 0;
	int       sink_stall_pct = 0;
	logic     hold_off       = 1'b0;

	integer_line_stepper #(
		.GRID_SIZE(GRID_CELLS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.line_valid (line_valid),
		.line_stall (line_stall),
		.line       (line),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point      (point)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// coordinates past the grid edge saturate to the last cell
	function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] c);
		return (c >= GRID_CELLS) ? COORD_W'(GRID_CELLS - 1) : c;
	endfunction

	// queue the raster points of one line, start first, end left out
	function automatic void trace_line(input line_req_t req);
		logic [COORD_W-1:0] sx, sy, ex, ey, dx, dy, major, minor, cur_x, cur_y;
		logic [ERR_W-1:0]   err;
		logic               y_major, major_down, minor_down;
		line_pt_t           pt;
		int                 left;
		sx = clamp_coord(req.start_x);
		sy = clamp_coord(req.start_y);
		ex = clamp_coord(req.end_x);
		ey = clamp_coord(req.end_y);
		dx = (sx >= ex) ? sx - ex : ex - sx;
		dy = (sy >= ey) ? sy - ey : ey - sy;
		// ties go to x
		y_major    = dx < dy;
		major_down = y_major ? (ey < sy) : (ex < sx);
		minor_down = y_major ? (ex < sx) : (ey < sy);
		major      = y_major ? dy : dx;
		minor      = y_major ? dx : dy;
		err        = ERR_W'(major >> 1);
		cur_x      = sx;
		cur_y      = sy;
		for (left = major; left > 0; left--) begin
			pt.point_x    = cur_x;
			pt.point_y    = cur_y;
			pt.last_point = (left == 1);
			expected_points = {expected_points, pt};
			if (y_major) begin
				cur_y = major_down ? cur_y - 1'b1 : cur_y + 1'b1;
			end else begin
				cur_x = major_down ? cur_x - 1'b1 : cur_x + 1'b1;
			end
			err = err + minor;
			// accumulator has caught up: step the minor axis
			if (err >= major) begin
				if (y_major) begin
					cur_x = minor_down ? cur_x - 1'b1 : cur_x + 1'b1;
				end else begin
					cur_y = minor_down ? cur_y - 1'b1 : cur_y + 1'b1;
				end
				err = err - major;
			end
		end
	endfunction

	function automatic line_req_t mk_line(input int sx, input int sy, input int ex,
			input int ey);
		line_req_t req;
		req.start_x = COORD_W'(sx);
		req.start_y = COORD_W'(sy);
		req.end_x   = COORD_W'(ex);
		req.end_y   = COORD_W'(ey);
		return req;
	endfunction

	// coordinate a few cells away, kept on the grid
	function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] c);
		int v;
		v = int'(c) + int'($urandom_range(10)) - 5;
		if (v < 0) v = 0;
		if (v > GRID_CELLS - 1) v = GRID_CELLS - 1;
		return COORD_W'(v);
	endfunction

	// arbitrary lines, with short, axis-aligned, diagonal, empty and
	// corner-to-corner lines mixed in
	function automatic line_req_t random_line();
		line_req_t req;
		int        pick;
		req  = REQ_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 20) begin
			req.end_x = nudge(req.start_x);
			req.end_y = nudge(req.start_y);
		end else if (pick < 28) begin
			req.end_y = req.start_y;
		end else if (pick < 36) begin
			req.end_x = req.start_x;
		end else if (pick < 40) begin
			req.start_y = req.start_x;
			req.end_y   = req.end_x;
		end else if (pick < 44) begin
			req.start_y = ~req.start_x;
			req.end_y   = ~req.end_x;
		end else if (pick < 48) begin
			req.end_x = req.start_x;
			req.end_y = req.start_y;
		end else if (pick < 52) begin
			req.start_x = $urandom_range(1) ? '1 : '0;
			req.start_y = $urandom_range(1) ? '1 : '0;
			req.end_x   = $urandom_range(1) ? '1 : '0;
			req.end_y   = $urandom_range(1) ? '1 : '0;
		end
		return req;
	endfunction

	// offer one item and hold it until taken, then maybe go idle for a while
	task automatic send_line(input line_req_t req);
		int gap;
		line       <= req;
		line_valid <= 1'b1;
		@(posedge clk);
		while (line_stall) @(posedge clk);
		lines_sent++;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct) gap++;
		if (gap != 0) begin
			line_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		// keep the log short on a badly broken block
		if (mismatches <= LOG_CAP) begin
			$display("%0t mismatch on point %0d: %s", $time, points_seen, msg);
		end
	endtask

	// receiver stall, forced high during a hold-off
	always @(posedge clk) begin
		point_stall <= hold_off || ($urandom_range(99) < sink_stall_pct);
	end

	// predict on each taken line, check each taken point
	always @(posedge clk) begin
		line_pt_t want;
		if (arst_n) begin
			if (line_valid && !line_stall) begin
				trace_line(line);
			end
			if (point_valid && !point_stall) begin
				points_seen++;
				if (expected_points.size() == 0) begin
					report_mismatch($sformatf("unexpected point (%0d,%0d)", point.point_x,
						point.point_y));
				end else begin
					want = expected_points.pop_front();
					if (point.point_x !== want.point_x)
						report_mismatch($sformatf("point_x %0d, expected %0d",
							point.point_x, want.point_x));
					if (point.point_y !== want.point_y)
						report_mismatch($sformatf("point_y %0d, expected %0d",
							point.point_y, want.point_y));
					if (point.last_point !== want.last_point)
						report_mismatch($sformatf("last_point %0b, expected %0b",
							point.last_point, want.last_point));
				end
			end
		end
	end

	// start and end on the same cell: nothing comes out
	task automatic test_equal_endpoints();
		send_line(mk_line(0, 0, 0, 0));
		send_line(mk_line(63, 63, 63, 63));
		send_line(mk_line(21, 42, 21, 42));
	endtask

	// horizontal and vertical lines both ways, full length and single point
	task automatic test_axis_lines();
		send_line(mk_line(0, 5, 63, 5));
		send_line(mk_line(63, 5, 0, 5));
		send_line(mk_line(7, 0, 7, 63));
		send_line(mk_line(7, 63, 7, 0));
		send_line(mk_line(10, 10, 11, 10));
		send_line(mk_line(10, 10, 10, 9));
	endtask

	// equal deltas, where x is the major axis
	task automatic test_diagonals_and_ties();
		send_line(mk_line(0, 0, 63, 63));
		send_line(mk_line(63, 63, 0, 0));
		send_line(mk_line(0, 63, 63, 0));
		send_line(mk_line(63, 0, 0, 63));
		send_line(mk_line(5, 5, 8, 2));
	endtask

	// shallow and steep lines in every direction from the centre, and one shallow line across the grid
	task automatic test_octants();
		send_line(mk_line(30, 30, 50, 37));
		send_line(mk_line(30, 30, 10, 37));
		send_line(mk_line(30, 30, 50, 23));
		send_line(mk_line(30, 30, 10, 23));
		send_line(mk_line(30, 30, 37, 50));
		send_line(mk_line(30, 30, 23, 50));
		send_line(mk_line(30, 30, 37, 10));
		send_line(mk_line(30, 30, 23, 10));
		send_line(mk_line(0, 0, 63, 1));
	endtask

	task automatic test_random_traffic(input int count, input int idle_pct,
			input int stall_pct);
		src_idle_pct    = idle_pct;
		sink_stall_pct <= stall_pct;
		repeat (count) send_line(random_line());
	endtask

	// receiver holds off while long lines keep coming, so the input backs up
	task automatic test_hold_off();
		src_idle_pct    = 0;
		sink_stall_pct <= 0;
		fork
			begin
				hold_off <= 1'b1;
				repeat (400) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		repeat (6) send_line(mk_line(0, 0, 63, $urandom_range(63)));
	endtask

	initial begin
		line_valid = 1'b0;
		line       = '0;
		arst_n     = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_equal_endpoints();
		test_axis_lines();
		test_diagonals_and_ties();
		test_octants();
		test_random_traffic(120, 0, 0);
		test_random_traffic(120, 85, 0);
		test_random_traffic(120, 0, 85);
		test_random_traffic(120, 22, 22);
		test_hold_off();

		// drain, then give the block time to show any stray point
		line_valid <= 1'b0;
		@(posedge clk);
		while (expected_points.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);

		$display("%0d lines sent, %0d points checked, %0d mismatches", lines_sent,
			points_seen, mismatches);
		$display("covered empty, axis, diagonal and octant lines under %s",
			"idle, stall and hold-off traffic");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("timeout with %0d points still expected", expected_points.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/ils_pkg.sv
src/ils_datapath.sv
src/ils_ctrl.sv
src/integer_line_stepper.sv
src/ils_checker.sv
bench/integer_line_stepper_tb.sv
